// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers included by the table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is held.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

`endif

// ===== hw/rtl/dost_pkg.sv =====
package dost_pkg;
  localparam int ENTRIES   = 256;
  localparam int KEY_BITS  = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int TIME_W    = 32;
  localparam int SCORE_W   = 31;
  localparam int CNT_W     = 32;
  localparam int REM_W     = 9;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [REM_W-1:0]   REM_MAX   = '1;
  localparam logic [TIME_W-1:0]  PERIOD_RST = 32'd60;

  // one table slot as stored in memory
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TIME_W-1:0]   last_time;
    logic [SCORE_W-1:0]  score;
  } slot_t;
endpackage

// ===== hw/rtl/dost_div.sv =====
// Restoring divider, one quotient bit per cycle.
module dost_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dost_pkg::TIME_W-1:0]   num,
  input  logic [dost_pkg::TIME_W-1:0]   den,
  output logic                          done,
  output logic [dost_pkg::TIME_W-1:0]   quo
);
  localparam int W  = dost_pkg::TIME_W;
  localparam int CW = $clog2(W);

  logic [W:0]    rem_r, rem_nxt, rem_sh;
  logic [W-1:0]  quo_r, quo_nxt, den_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;

  // one shift-subtract step
  always_comb begin
    rem_sh  = {rem_r[W-1:0], quo_r[W-1]};
    quo_nxt = {quo_r[W-2:0], 1'b0};
    rem_nxt = rem_sh;
    if (rem_sh >= {1'b0, den_r}) begin
      rem_nxt    = rem_sh - {1'b0, den_r};
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= num;
        den_r <= den;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W-1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ===== hw/rtl/decaying_offender_score_table_unit.sv =====
// Access: a scan of the table (stops early on a hit), plus the divider on a hit
//   or an insert on a miss, then the result is posted.
// Clean: per slot a read and a compare, plus the divider for a valid slot.
// One item at a time; the next item is taken the cycle after the result posts.
// Synchronous active-low reset clears all valid bits, the access counter and
//   restores expire_period to 60; slot contents are left as they are.
module decaying_offender_score_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [63:0] in_id_key,
  input  logic [31:0] in_now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_score,
  output logic [31:0] out_accesses_since_clean,
  output logic [8:0]  out_removed_entries,
  output logic        out_table_full
);
  `include "assert_macros.svh"

  localparam int N   = dost_pkg::ENTRIES;
  localparam int IW  = dost_pkg::IDX_W;
  localparam int KW  = dost_pkg::KEY_BITS;
  localparam int TW  = dost_pkg::TIME_W;
  localparam int SW  = dost_pkg::SCORE_W;
  localparam logic [IW-1:0] IDX_LAST = IW'(N-1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_INS, S_CRD, S_CCMP, S_DSTART, S_DWAIT, S_FIN
  } state_t;

  state_t state_r;

  // slot memory, one read and one write port
  dost_pkg::slot_t mem [N];
  dost_pkg::slot_t rd_q, wr_data;
  logic [IW-1:0]   rd_addr, wr_addr;
  logic            wr_en;
  logic [N-1:0]    valid_r;

  logic [TW-1:0]   period_r, now_r;
  logic [KW-1:0]   key_r;
  logic            clean_r;
  logic [IW-1:0]   idx_r, cmp_idx_r, hit_idx_r, free_idx_r;
  logic            issue_done_r, cmp_vld_r, free_found_r;
  logic [TW-1:0]   ent_time_r;
  logic [SW-1:0]   ent_score_r;
  logic [dost_pkg::CNT_W-1:0] acc_cnt_r;
  logic [dost_pkg::REM_W-1:0] removed_r;
  logic [SW-1:0]   res_score_r;
  logic            res_full_r;

  logic            out_valid_r, out_full_r;
  logic [SW-1:0]   out_score_r;
  logic [31:0]     out_acc_r;
  logic [8:0]      out_rem_r;

  // divider hookup
  logic            div_start, div_done;
  logic [TW-1:0]   div_num, div_den, div_quo;

  assign div_start = (state_r == S_DSTART);
  assign div_num   = (now_r >= ent_time_r) ? (now_r - ent_time_r) : '0;
  assign div_den   = (period_r == '0) ? TW'(1) : period_r;

  dost_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // decay math on the divider result
  logic          dec_neg;
  logic [SW-1:0] dec_val, ret_val, store_val;
  always_comb begin
    dec_neg   = div_quo > TW'(ent_score_r);
    dec_val   = ent_score_r - div_quo[SW-1:0];
    ret_val   = (dec_neg || dec_val == '0) ? SW'(1) : dec_val;
    store_val = (ret_val == dost_pkg::SCORE_MAX) ? ret_val : ret_val + 1'b1;
  end

  logic cmp_hit, cmp_free;
  assign cmp_hit  = cmp_vld_r && valid_r[cmp_idx_r] && (rd_q.key == key_r);
  assign cmp_free = cmp_vld_r && !valid_r[cmp_idx_r];

  // memory port control
  always_comb begin
    rd_addr = idx_r;
    wr_en   = 1'b0;
    wr_addr = hit_idx_r;
    wr_data = '{key: key_r, last_time: now_r, score: store_val};
    if (state_r == S_INS) begin
      wr_en   = !free_found_r ? 1'b0 : 1'b1;
      wr_addr = free_idx_r;
      wr_data = '{key: key_r, last_time: now_r, score: SW'(2)};
    end else if (state_r == S_DWAIT && div_done) begin
      if (clean_r) begin
        wr_en   = !dec_neg;
        wr_addr = idx_r;
        wr_data = '{key: rd_q.key, last_time: now_r, score: dec_val};
      end else begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  assign in_ready = (state_r == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      acc_cnt_r   <= '0;
      period_r    <= dost_pkg::PERIOD_RST;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) period_r <= cfg_wdata;
      // S_FIN reloads the output register itself
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      // a compare is pending in the cycle after each scan read
      cmp_vld_r <= (state_r == S_SCAN) && !issue_done_r && !cmp_hit;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            clean_r      <= in_req_type;
            key_r        <= in_id_key[KW-1:0];
            now_r        <= in_now_time;
            idx_r        <= '0;
            issue_done_r <= 1'b0;
            free_found_r <= 1'b0;
            removed_r    <= '0;
            res_full_r   <= 1'b0;
            res_score_r  <= '0;
            if (in_req_type) begin
              state_r <= S_CRD;
            end else begin
              state_r <= S_SCAN;
              if (acc_cnt_r != dost_pkg::CNT_MAX) acc_cnt_r <= acc_cnt_r + 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (!issue_done_r) begin
            idx_r <= idx_r + 1'b1;
            if (idx_r == IDX_LAST) issue_done_r <= 1'b1;
          end
          cmp_idx_r <= idx_r;
          if (cmp_free && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= cmp_idx_r;
          end
          if (cmp_hit) begin
            hit_idx_r   <= cmp_idx_r;
            ent_time_r  <= rd_q.last_time;
            ent_score_r <= rd_q.score;
            state_r     <= S_DSTART;
          end else if (cmp_vld_r && cmp_idx_r == IDX_LAST) begin
            state_r <= S_INS;
          end
        end
        S_INS: begin
          res_score_r <= SW'(1);
          res_full_r  <= !free_found_r;
          if (free_found_r) valid_r[free_idx_r] <= 1'b1;
          state_r <= S_FIN;
        end
        S_CRD: state_r <= S_CCMP;
        S_CCMP: begin
          if (valid_r[idx_r]) begin
            ent_time_r  <= rd_q.last_time;
            ent_score_r <= rd_q.score;
            state_r     <= S_DSTART;
          end else if (idx_r == IDX_LAST) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_CRD;
          end
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            if (clean_r) begin
              if (dec_neg) begin
                valid_r[idx_r] <= 1'b0;
                if (removed_r != dost_pkg::REM_MAX) removed_r <= removed_r + 1'b1;
              end
              if (idx_r == IDX_LAST) begin
                state_r <= S_FIN;
              end else begin
                idx_r   <= idx_r + 1'b1;
                state_r <= S_CRD;
              end
            end else begin
              res_score_r <= ret_val;
              state_r     <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_score_r <= res_score_r;
            out_full_r  <= res_full_r;
            out_rem_r   <= removed_r;
            out_acc_r   <= clean_r ? '0 : acc_cnt_r;
            if (clean_r) acc_cnt_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid                = out_valid_r;
  assign out_score                = out_score_r;
  assign out_accesses_since_clean = out_acc_r;
  assign out_removed_entries      = out_rem_r;
  assign out_table_full           = out_full_r;

  // a full table reports the floor score and no removals
  `ASSERT_CLKD(a_full_score, clk, rst_n, out_valid_r && out_full_r |-> out_score_r == SW'(1) && out_rem_r == '0)
  // divider completes only while the sequencer waits on it
  `ASSERT_CLKD(a_div_wait, clk, rst_n, div_done |-> state_r == S_DWAIT)
  // a clean that removed entries reports a zero score and a zero counter
  `ASSERT_CLKD(a_clean_out, clk, rst_n, out_valid_r && out_rem_r != '0 |-> out_score_r == '0 && out_acc_r == '0)
endmodule
